// ----- sv/prla_pkg.sv -----
package prla_pkg;

	typedef enum logic [2:0] {
		FN_PROPOSE  = 3'd0,
		FN_PREPARE  = 3'd1,
		FN_PACK     = 3'd2,
		FN_ACCEPT   = 3'd3,
		FN_LEARN    = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		K_SEND_ACCEPT = 3'd0,
		K_SEND_PACK   = 3'd1,
		K_BC_PROPOSE  = 3'd2,
		K_BC_LEARN    = 3'd3,
		K_SEND_LEARN  = 3'd4,
		K_LEARNED     = 3'd5,
		K_SUGGEST     = 3'd6
	} kind_t;

	localparam logic REG_NUM_SERVERS = 1'b0;
	localparam logic REG_INSTANCE_ID = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // take request into working registers
		logic decide;    // evaluate request, update state, build results
		logic scan_step; // one record of the quorum scan
		logic scan_done; // build propose result from scan winner
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;  // promise replies reached quorum
		logic [1:0] nres; // results of the request (0..2)
		logic scan_last;  // scan at final record
	} stat_t;

endpackage

// ----- sv/paxos_round_acceptor_learner.sv -----
// Channel  | handshake          | payload
// input    | in_valid/in_stall  | func sender ballot value value_noop acked_*
// output   | out_valid/out_stall| kind dest out_ballot out_accepted_ballot out_value out_noop last
// config   | cfg_we             | cfg_index cfg_data
//
// A request passes a capture state and a decide state, then an emit state
// per result. A promise reply that reaches quorum adds a scan of all
// MAX_SERVERS records of the ack record store (one record per cycle).
// Results are held while out_stall is high; input is stalled while busy.
// arst_n clears control and consensus state; the record store has no reset.
module paxos_round_acceptor_learner #(
	parameter int MAX_SERVERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [3:0]  sender,
	input  logic [30:0] ballot,
	input  logic [31:0] value,
	input  logic        value_noop,
	input  logic signed [31:0] acked_ballot,
	input  logic [31:0] acked_value,
	input  logic        acked_noop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [3:0]  dest,
	output logic signed [31:0] out_ballot,
	output logic signed [31:0] out_accepted_ballot,
	output logic [31:0] out_value,
	output logic        out_noop,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import prla_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  out_sel;

	// sequencer: capture, decide, optional quorum scan, result emission
	prla_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.out_sel, .cmd, .stat
	);

	// consensus state, record store and result registers
	prla_dp #(.MAX_SERVERS(MAX_SERVERS)) u_dp (
		.clk, .arst_n, .func, .sender, .ballot, .value, .value_noop,
		.acked_ballot, .acked_value, .acked_noop,
		.cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.cmd, .stat, .out_sel,
		.kind, .dest, .out_ballot, .out_accepted_ballot, .out_value,
		.out_noop, .last
	);

endmodule

// ----- sv/prla_ctrl.sv -----
module prla_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             out_sel,
	output prla_pkg::cmd_t   cmd,
	input  prla_pkg::stat_t  stat
);
	import prla_pkg::*;

	state_t state_q, state_d;
	logic   two_q, two_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			two_q <= 1'b0;
		end else begin
			state_q <= state_d;
			two_q <= two_d;
		end
	end

	always_comb begin
		state_d = state_q;
		two_d = two_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		out_sel = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				two_d = (stat.nres == 2'd2);
				if (stat.need_scan) state_d = ST_SCAN;
				else if (stat.nres == 2'd0) state_d = ST_IDLE;
				else state_d = ST_EMIT0;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					cmd.scan_done = 1'b1;
					two_d = 1'b0;
					state_d = ST_EMIT0;
				end
			end
			ST_EMIT0: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = two_q ? ST_EMIT1 : ST_IDLE;
			end
			ST_EMIT1: begin
				out_valid = 1'b1;
				out_sel = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- sv/prla_dp.sv -----
module prla_dp #(
	parameter int MAX_SERVERS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      func,
	input  logic [3:0]      sender,
	input  logic [30:0]     ballot,
	input  logic [31:0]     value,
	input  logic            value_noop,
	input  logic signed [31:0] acked_ballot,
	input  logic [31:0]     acked_value,
	input  logic            acked_noop,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [31:0]     cfg_data,
	input  prla_pkg::cmd_t  cmd,
	output prla_pkg::stat_t stat,
	input  logic            out_sel,
	output logic [2:0]      kind,
	output logic [3:0]      dest,
	output logic signed [31:0] out_ballot,
	output logic signed [31:0] out_accepted_ballot,
	output logic [31:0]     out_value,
	output logic            out_noop,
	output logic            last
);
	import prla_pkg::*;

	localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CW = $clog2(MAX_SERVERS + 1);

	typedef struct packed {
		logic [2:0]         kind;
		logic [3:0]         dest;
		logic signed [31:0] bal;
		logic signed [31:0] abal;
		logic [31:0]        val;
		logic               noop;
		logic               last;
	} res_t;

	// configuration
	logic [4:0]  num_servers_q;
	logic [31:0] instance_id_q;  // stored only

	// consensus state
	logic               learned_q;
	logic [31:0]        lval_q;
	logic               lnoop_q;
	logic signed [32:0] promised_q;
	logic signed [32:0] taken_bal_q;
	logic [31:0]        taken_val_q;
	logic               taken_noop_q;
	logic [MAX_SERVERS-1:0] ack_seen_q, accept_seen_q;

	// ack record store (no reset)
	logic signed [31:0] rec_bal [MAX_SERVERS];
	logic [31:0]        rec_val [MAX_SERVERS];
	logic               rec_noop[MAX_SERVERS];

	// captured request
	logic [2:0]         func_q;
	logic [3:0]         snd_q;
	logic [30:0]        bal_q;
	logic [31:0]        val_q;
	logic               vnoop_q;
	logic signed [31:0] abal_q;
	logic [31:0]        aval_q;
	logic               anoop_q;

	// scan
	logic [IW-1:0]      idx_q;
	logic signed [31:0] best_q;
	logic [31:0]        bv_q;
	logic               bn_q;

	res_t res0_q, res1_q;

	// -------- combinational decision --------
	logic [CW-1:0] ack_cnt, acc_cnt;
	logic [4:0]    quorum;
	logic          in_range;
	logic [IW-1:0] snd_idx;
	logic [MAX_SERVERS-1:0] bitm, ack_new, acc_new;
	logic signed [32:0] bal_x;
	res_t r0, r1, rp;
	logic [1:0] nres;
	logic need_scan;

	assign quorum = 5'((6'(num_servers_q) + 6'd2) >> 1);
	assign in_range = (32'(snd_q) < 32'(MAX_SERVERS));
	assign snd_idx = IW'(snd_q);
	assign bal_x = {2'b00, bal_q};

	always_comb begin
		bitm = '0;
		if (in_range) bitm[snd_idx] = 1'b1;
	end
	assign ack_new = ack_seen_q | bitm;
	assign acc_new = accept_seen_q | bitm;

	always_comb begin
		ack_cnt = '0;
		acc_cnt = '0;
		for (int i = 0; i < MAX_SERVERS; i++) begin
			ack_cnt = ack_cnt + CW'(ack_new[i]);
			acc_cnt = acc_cnt + CW'(acc_new[i]);
		end
	end

	always_comb begin
		r0 = '0;
		r1 = '0;
		nres = 2'd0;
		need_scan = 1'b0;
		r0.last = 1'b1;
		r1.last = 1'b1;
		if (func_q == FN_LEARN) begin
			r0.kind = K_LEARNED; r0.val = val_q; r0.noop = vnoop_q; nres = 2'd1;
		end else if (func_q > FN_LEARN) begin
			nres = 2'd0;
		end else if (learned_q) begin
			r0.kind = K_SEND_LEARN; r0.dest = snd_q;
			r0.val = lval_q; r0.noop = lnoop_q; nres = 2'd1;
		end else if (func_q == FN_PROPOSE) begin
			if (bal_q == '0 && vnoop_q) begin
				r0.kind = K_LEARNED; r0.noop = 1'b1; nres = 2'd1;
			end else if (promised_q <= bal_x && taken_bal_q < bal_x) begin
				if (bal_q == '0) begin
					r0.kind = K_SUGGEST; r0.last = 1'b0;
					r1.kind = K_SEND_ACCEPT; r1.dest = snd_q;
					r1.bal = 32'(bal_q); r1.val = val_q; r1.noop = vnoop_q;
					nres = 2'd2;
				end else begin
					r0.kind = K_SEND_ACCEPT; r0.dest = snd_q;
					r0.bal = 32'(bal_q); r0.val = val_q; r0.noop = vnoop_q;
					nres = 2'd1;
				end
			end else begin
				r0.kind = K_SEND_ACCEPT; r0.dest = snd_q;
				r0.bal = taken_bal_q[31:0]; r0.val = taken_val_q;
				r0.noop = taken_noop_q; nres = 2'd1;
			end
		end else if (func_q == FN_PREPARE) begin
			if (bal_x > promised_q) begin
				r0.kind = K_SEND_PACK; r0.dest = snd_q; r0.bal = 32'(bal_q);
				r0.abal = taken_bal_q[31:0]; r0.val = taken_val_q;
				r0.noop = taken_noop_q; nres = 2'd1;
			end
		end else if (!in_range) begin
			nres = 2'd0;
		end else if (func_q == FN_PACK) begin
			need_scan = (5'(ack_cnt) == quorum);
		end else begin
			if (5'(acc_cnt) == quorum) begin
				r0.kind = K_BC_LEARN; r0.val = val_q; r0.noop = vnoop_q; nres = 2'd1;
			end
		end
	end

	// propose result from the scan winner, last record folded in
	always_comb begin
		rp = '0;
		rp.kind = K_BC_PROPOSE;
		rp.bal = 32'(bal_q);
		rp.last = 1'b1;
		if (ack_seen_q[idx_q] && rec_bal[idx_q] > best_q) begin
			rp.val = rec_val[idx_q]; rp.noop = rec_noop[idx_q];
		end else begin
			rp.val = bv_q; rp.noop = bn_q;
		end
	end

	assign stat.need_scan = need_scan;
	assign stat.nres = nres;
	assign stat.scan_last = (32'(idx_q) == 32'(MAX_SERVERS - 1));

	// -------- registers --------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_servers_q <= 5'd3;
			instance_id_q <= '0;
			learned_q <= 1'b0;
			lval_q <= '0;
			lnoop_q <= 1'b0;
			promised_q <= '0;
			taken_bal_q <= -33'sd1;
			taken_val_q <= '0;
			taken_noop_q <= 1'b1;
			ack_seen_q <= '0;
			accept_seen_q <= '0;
			idx_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_NUM_SERVERS) num_servers_q <= cfg_data[4:0];
				else instance_id_q <= cfg_data;
			end
			if (cmd.decide) begin
				idx_q <= '0;
				if (func_q == FN_LEARN) begin
					learned_q <= 1'b1; lval_q <= val_q; lnoop_q <= vnoop_q;
				end else if (!learned_q && func_q < FN_LEARN) begin
					if (func_q == FN_PROPOSE) begin
						if (bal_q == '0 && vnoop_q) begin
							learned_q <= 1'b1; lval_q <= '0; lnoop_q <= 1'b1;
						end else if (promised_q <= bal_x && taken_bal_q < bal_x) begin
							taken_bal_q <= bal_x; taken_val_q <= val_q;
							taken_noop_q <= vnoop_q;
						end
					end else if (func_q == FN_PREPARE) begin
						if (bal_x > promised_q) promised_q <= bal_x;
					end else if (in_range) begin
						if (func_q == FN_PACK) ack_seen_q <= ack_new;
						else accept_seen_q <= acc_new;
					end
				end
			end
			if (cmd.scan_step) idx_q <= idx_q + IW'(1);
		end
	end

	// record store write
	always_ff @(posedge clk) begin
		if (cmd.decide && !learned_q && func_q == FN_PACK && in_range) begin
			rec_bal[snd_idx]  <= abal_q;
			rec_val[snd_idx]  <= aval_q;
			rec_noop[snd_idx] <= anoop_q;
		end
	end

	// capture, scan, results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func; snd_q <= sender; bal_q <= ballot; val_q <= value;
			vnoop_q <= value_noop; abal_q <= acked_ballot;
			aval_q <= acked_value; anoop_q <= acked_noop;
		end
		if (cmd.decide) begin
			res0_q <= r0;
			res1_q <= r1;
			best_q <= -32'sd1; bv_q <= '0; bn_q <= 1'b1;
		end
		if (cmd.scan_step) begin
			if (ack_seen_q[idx_q] && rec_bal[idx_q] > best_q) begin
				best_q <= rec_bal[idx_q]; bv_q <= rec_val[idx_q];
				bn_q <= rec_noop[idx_q];
			end
		end
		if (cmd.scan_done) res0_q <= rp;
	end

	res_t ro;
	assign ro = out_sel ? res1_q : res0_q;
	assign kind = ro.kind;
	assign dest = ro.dest;
	assign out_ballot = ro.bal;
	assign out_accepted_ballot = ro.abal;
	assign out_value = ro.val;
	assign out_noop = ro.noop;
	assign last = ro.last;

endmodule

// ----- sv/prla_chk.sv -----
module prla_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] kind,
	input logic       last
);
	import prla_pkg::*;

	// never take a request while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during output");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
		else $error("result changed under stall");

	// suggestion notice is never final
	a_sugg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_SUGGEST |-> !last) else $error("suggest last");

	// a non-final result is followed by another result
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("missing second result");

endmodule

bind paxos_round_acceptor_learner prla_chk u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .kind, .last
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import prla_pkg::*;

	// one consensus request as driven on the input channel
	typedef struct {
		logic [2:0]  fn;
		logic [3:0]  snd;
		logic [30:0] bal;
		logic [31:0] val;
		logic        vnoop;
		logic [31:0] abal;
		logic [31:0] aval;
		logic        anoop;
	} req_t;

	// one action or notice as seen on the output channel
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  dest;
		logic [31:0] bal;
		logic [31:0] abal;
		logic [31:0] val;
		logic        noop;
		logic        last;
	} act_t;

	// Tracks the acceptor/learner state and the actions it owes.
	class paxos_scoreboard;
		act_t        owed[$];
		int          mismatches;
		// replica state
		logic [4:0]  nsrv;
		logic [31:0] inst;
		bit          learned;
		logic [31:0] learned_val;
		logic        learned_noop;
		int          promised;
		int          taken_bal;
		logic [31:0] taken_val;
		logic        taken_noop;
		logic [15:0] ack_seen;
		logic [15:0] acc_seen;
		int          rec_bal[16];
		logic [31:0] rec_val[16];
		logic        rec_noop[16];

		function new();
			nsrv = 5'd3;
			inst = '0;
			learned = 0;
			learned_val = '0;
			learned_noop = 0;
			promised = 0;
			taken_bal = -1;
			taken_val = '0;
			taken_noop = 1;
			ack_seen = '0;
			acc_seen = '0;
			mismatches = 0;
		endfunction

		function void push(kind_t k, logic [3:0] d, int b, int ab, logic [31:0] v,
				logic n, logic l);
			act_t a;
			a.kind = k; a.dest = d; a.bal = b; a.abal = ab;
			a.val = v; a.noop = n; a.last = l;
			owed.push_back(a);
		endfunction

		function void set_reg(logic idx, logic [31:0] data);
			if (idx == REG_NUM_SERVERS)
				nsrv = data[4:0];
			else
				inst = data;
		endfunction

		// work out what the replica owes for one accepted request
		function void note_request(req_t r);
			int b;
			int best;
			logic [31:0] bv;
			logic bn;
			b = int'({1'b0, r.bal});
			if (r.fn > FN_LEARN)
				return;
			if (r.fn == FN_LEARN) begin
				learned = 1;
				learned_val = r.val;
				learned_noop = r.vnoop;
				push(K_LEARNED, 0, 0, 0, r.val, r.vnoop, 1);
				return;
			end
			// once decided, everyone just gets told the outcome
			if (learned) begin
				push(K_SEND_LEARN, r.snd, 0, 0, learned_val, learned_noop, 1);
				return;
			end
			case (r.fn)
				FN_PROPOSE: begin
					if (b == 0 && r.vnoop) begin
						learned = 1;
						learned_val = '0;
						learned_noop = 1;
						push(K_LEARNED, 0, 0, 0, 0, 1, 1);
					end else if (promised <= b && taken_bal < b) begin
						if (b == 0)
							push(K_SUGGEST, 0, 0, 0, 0, 0, 0);
						taken_bal = b;
						taken_val = r.val;
						taken_noop = r.vnoop;
						push(K_SEND_ACCEPT, r.snd, b, 0, r.val, r.vnoop, 1);
					end else begin
						// stale: replay what we hold
						push(K_SEND_ACCEPT, r.snd, taken_bal, 0, taken_val, taken_noop, 1);
					end
				end
				FN_PREPARE: begin
					if (b > promised) begin
						promised = b;
						push(K_SEND_PACK, r.snd, b, taken_bal, taken_val, taken_noop, 1);
					end
				end
				FN_PACK: begin
					ack_seen[r.snd] = 1'b1;
					rec_bal[r.snd] = int'(r.abal);
					rec_val[r.snd] = r.aval;
					rec_noop[r.snd] = r.anoop;
					if ($countones(ack_seen) == (int'(nsrv) + 2) / 2) begin
						best = -1;
						bv = '0;
						bn = 1;
						// strict compare keeps lowest sender on ties
						for (int i = 0; i < 16; i++)
							if (ack_seen[i] && rec_bal[i] > best) begin
								best = rec_bal[i];
								bv = rec_val[i];
								bn = rec_noop[i];
							end
						push(K_BC_PROPOSE, 0, b, 0, bv, bn, 1);
					end
				end
				default: begin
					acc_seen[r.snd] = 1'b1;
					if ($countones(acc_seen) == (int'(nsrv) + 2) / 2)
						push(K_BC_LEARN, 0, 0, 0, r.val, r.vnoop, 1);
				end
			endcase
		endfunction

		function void check_action(act_t got);
			act_t w;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d dest=%0d", got.kind, got.dest);
				return;
			end
			w = owed.pop_front();
			if (got !== w) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp kind=%0d dest=%0d bal=%h abal=%h val=%h %s",
						w.kind, w.dest, w.bal, w.abal, w.val,
						$sformatf("noop=%b last=%b", w.noop, w.last));
					$display("          got kind=%0d dest=%0d bal=%h abal=%h val=%h %s",
						got.kind, got.dest, got.bal, got.abal, got.val,
						$sformatf("noop=%b last=%b", got.noop, got.last));
				end
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  func = '0;
	logic [3:0]  sender = '0;
	logic [30:0] ballot = '0;
	logic [31:0] value = '0;
	logic        value_noop = 0;
	logic signed [31:0] acked_ballot = '0;
	logic [31:0] acked_value = '0;
	logic        acked_noop = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  kind;
	logic [3:0]  dest;
	logic signed [31:0] out_ballot;
	logic signed [31:0] out_accepted_ballot;
	logic [31:0] out_value;
	logic        out_noop;
	logic        last;
	logic        cfg_we = 0;
	logic        cfg_index = REG_NUM_SERVERS;
	logic [31:0] cfg_data = '0;

	paxos_round_acceptor_learner uut (.*);

	paxos_scoreboard sb = new();
	int  send_idle_pct = 0;   // sender gap chance, percent
	int  stall_pct = 0;       // receiver stall chance, percent
	int  cycles = 0;
	localparam int CYCLE_LIMIT = 400000;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stall at falling edge, check at rising edge
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		act_t a;
		if (arst_n && out_valid && !out_stall) begin
			a.kind = kind_t'(kind);
			a.dest = dest;
			a.bal = out_ballot;
			a.abal = out_accepted_ballot;
			a.val = out_value;
			a.noop = out_noop;
			a.last = last;
			sb.check_action(a);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_request(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		in_valid = 1;
		func = r.fn; sender = r.snd; ballot = r.bal; value = r.val;
		value_noop = r.vnoop; acked_ballot = r.abal; acked_value = r.aval;
		acked_noop = r.anoop;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// drain outstanding results, then allow for a scan still running
	task automatic drain();
		in_valid = 0;
		@(negedge clk);
		while (sb.owed.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	function automatic req_t mk(logic [2:0] f, logic [3:0] s, logic [30:0] b,
			logic [31:0] v, logic vn, logic [31:0] ab, logic [31:0] av, logic an);
		req_t r;
		r.fn = f; r.snd = s; r.bal = b; r.val = v; r.vnoop = vn;
		r.abal = ab; r.aval = av; r.anoop = an;
		return r;
	endfunction

	// random request; decisions (learn, no-op propose at zero) only when allowed
	function automatic req_t rand_req(int max_snd, bit allow_decide);
		req_t r;
		int p;
		p = $urandom_range(99);
		if (p < 20) r.fn = FN_PROPOSE;
		else if (p < 40) r.fn = FN_PREPARE;
		else if (p < 70) r.fn = FN_PACK;
		else if (p < 93) r.fn = FN_ACCEPT;
		else if (p < 96 && allow_decide) r.fn = FN_LEARN;
		else r.fn = 3'($urandom_range(5, 7));
		r.snd = 4'($urandom_range(max_snd));
		r.bal = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(40));
		r.val = $urandom;
		r.vnoop = $urandom_range(1);
		if (!allow_decide && r.fn == FN_PROPOSE && r.bal == 0)
			r.vnoop = 0;
		p = $urandom_range(9);
		r.abal = (p < 3) ? 32'hffff_ffff :
			(p < 8) ? 32'($urandom_range(40)) : {1'b0, 31'($urandom)};
		r.aval = $urandom;
		r.anoop = $urandom_range(1);
		return r;
	endfunction

	initial begin
		int n_srv[4];
		int max_snd[4];
		int idle_in[4];
		int idle_out[4];
		n_srv = '{7, 16, 1, 16};
		max_snd = '{3, 8, 15, 15};
		idle_in = '{0, 56, 0, 35};
		idle_out = '{0, 0, 56, 35};

		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: quorum of 2 at reset size
		send_request(mk(FN_PROPOSE, 1, 0, 32'h1234_5678, 0, 0, 0, 0)); // suggestion first
		send_request(mk(FN_PROPOSE, 2, 0, 32'h0, 0, 0, 0, 0));         // stale, replay
		send_request(mk(FN_PREPARE, 3, 5, 0, 0, 0, 0, 0));
		send_request(mk(FN_PREPARE, 3, 5, 0, 0, 0, 0, 0));             // stale prepare
		send_request(mk(FN_PROPOSE, 4, 3, 32'hdead_beef, 1, 0, 0, 0)); // below promise
		send_request(mk(FN_PROPOSE, 15, 31'h7fff_ffff, 32'hffff_ffff, 1, 0, 0, 0));
		send_request(mk(FN_PACK, 2, 7, 0, 0, 9, 32'haaaa_0002, 0));
		send_request(mk(FN_PACK, 1, 8, 0, 0, 9, 32'haaaa_0001, 1));    // tie, lowest id
		send_request(mk(FN_PACK, 2, 9, 0, 0, 32'hffff_ffff, 0, 0));    // same count again
		send_request(mk(FN_PACK, 15, 31'h7fff_ffff, 32'hffff_ffff, 1,
			32'h7fff_ffff, 32'hffff_ffff, 1));
		send_request(mk(FN_PACK, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(FN_ACCEPT, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(FN_ACCEPT, 15, 31'h7fff_ffff, 32'hffff_ffff, 1, 0, 0, 0));
		send_request(mk(FN_ACCEPT, 15, 0, 32'h5555_aaaa, 0, 0, 0, 0)); // repeat quorum
		send_request(mk(3'd5, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(3'd6, 7, 1, 1, 1, 1, 1, 1));
		send_request(mk(3'd7, 15, 31'h7fff_ffff, 32'hffff_ffff, 1,
			32'hffff_ffff, 32'hffff_ffff, 1));
		send_request(mk(FN_PREPARE, 0, 31'h7fff_ffff, 0, 0, 0, 0, 0));
		send_request(mk(FN_PROPOSE, 9, 6, 32'h0bad_f00d, 0, 0, 0, 0));  // below promise
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_NUM_SERVERS, 32'(n_srv[ph]));
			write_reg(REG_INSTANCE_ID, (ph == 1) ? 32'hffff_ffff : (ph == 2) ? 32'h0 : $urandom);
			send_idle_pct = idle_in[ph];
			stall_pct = idle_out[ph];
			// last phase may decide the instance, so it comes last
			for (int i = 0; i < 235; i++)
				send_request(rand_req(max_snd[ph], ph == 3));
			drain();
		end

		// a known decision at the very end
		send_request(mk(FN_PROPOSE, 5, 0, 32'h0, 1, 0, 0, 0));
		send_request(mk(FN_LEARN, 6, 0, 32'hffff_ffff, 0, 0, 0, 0));
		send_request(mk(FN_PREPARE, 7, 31'h7fff_ffff, 0, 0, 0, 0, 0));
		drain();

		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
